// ===== src/jdtm_pkg.sv =====
// ----------------------------------------------------------------------------
// jdtm_pkg
// Shared types and constants of the joystick differential thrust mixer.
// ----------------------------------------------------------------------------
package jdtm_pkg;

  // configuration register indexes
  localparam logic REG_MAX_DRIVE      = 1'b0;
  localparam logic REG_SECTOR_TANGENT = 1'b1;

  localparam logic [6:0]  MAX_DRIVE_RESET      = 7'd60;
  localparam logic [15:0] SECTOR_TANGENT_RESET = 16'd5721;

  // stick code span
  localparam logic [11:0] CODE_LO   = 12'd32;
  localparam logic [11:0] CODE_HI   = 12'd992;
  localparam logic [9:0]  CODE_SPAN = 10'd960;

  // ceil(2^24 / 15): floor(p / 15) for p below 2^20
  localparam logic [20:0] RECIP15 = 21'd1118482;

  localparam logic signed [11:0] NEUTRAL = 12'sd500;
  localparam logic [9:0]         POWER_MAX = 10'd1000;

  // pipeline stage map
  localparam int ST_SCALE     = 0;
  localparam int ST_RECIP     = 1;
  localparam int ST_DRIVE     = 2;
  localparam int ST_SQUARE    = 3;
  localparam int ST_MODE      = 4;
  localparam int ST_ROOT      = 5;
  localparam int ST_PROD      = 6;
  localparam int CORDIC_FIRST = 4;
  localparam int CORDIC_STEPS = 15;
  localparam int ST_ANGLE     = CORDIC_FIRST + CORDIC_STEPS;
  localparam int ST_DIVCHK    = ST_ANGLE + 1;
  localparam int DIV_FIRST    = ST_DIVCHK + 1;
  localparam int DIV_BITS     = 10;
  localparam int ST_FINAL     = DIV_FIRST + DIV_BITS;
  localparam int NSTG         = ST_FINAL + 1;

  // arctangent of 2^-i in Q2.14 radians
  localparam logic signed [15:0] ATAN_TAB [CORDIC_STEPS] = '{
    16'sd12868, 16'sd7596, 16'sd4014, 16'sd2037, 16'sd1023, 16'sd512, 16'sd256,
    16'sd128, 16'sd64, 16'sd32, 16'sd16, 16'sd8, 16'sd4, 16'sd2, 16'sd1
  };

  typedef enum logic [2:0] {
    MODE_Q1,
    MODE_Q2,
    MODE_Q3,
    MODE_Q4,
    MODE_CONE,
    MODE_STBD,
    MODE_PORT
  } mode_t;

  typedef struct packed {
    logic [6:0]  max_drive;
    logic [15:0] sector_tangent;
  } cfg_t;

  // everything an item carries down the pipeline
  typedef struct packed {
    logic               stop;
    logic [11:0]        xc;
    logic [11:0]        yc;
    logic [19:0]        px;
    logic [19:0]        py;
    logic [15:0]        qx;
    logic [15:0]        qy;
    logic signed [15:0] xd;
    logic signed [15:0] yd;
    logic [14:0]        ax;
    logic [14:0]        ay;
    logic [29:0]        xx;
    logic [29:0]        yy;
    logic [30:0]        tax;
    logic [30:0]        tay;
    logic [30:0]        s;
    logic signed [30:0] d;
    mode_t              mode;
    logic [7:0]         r;
    logic [37:0]        dprod;
    logic               dneg;
    logic signed [26:0] cx;
    logic signed [26:0] cy;
    logic signed [15:0] cz;
    logic [38:0]        a;
    logic [30:0]        dv;
    logic               neg;
    logic               ovf;
    logic               dz;
    logic [9:0]         q;
    logic [9:0]         left;
    logic [9:0]         right;
  } item_t;

endpackage

// ===== src/jdtm_joy_if.sv =====
// ----------------------------------------------------------------------------
// jdtm_joy_if
// Joystick sample channel.
// ----------------------------------------------------------------------------
interface jdtm_joy_if;
  logic        valid;
  logic        ready;
  logic [11:0] x_code;
  logic [11:0] y_code;
  logic        stop_request;

  modport source (output valid, x_code, y_code, stop_request, input ready);
  modport sink (input valid, x_code, y_code, stop_request, output ready);
endinterface

// ===== src/jdtm_thrust_if.sv =====
// ----------------------------------------------------------------------------
// jdtm_thrust_if
// Thruster command channel.
// ----------------------------------------------------------------------------
interface jdtm_thrust_if;
  logic       valid;
  logic       ready;
  logic [9:0] left_power;
  logic [9:0] right_power;

  modport source (output valid, left_power, right_power, input ready);
  modport sink (input valid, left_power, right_power, output ready);
endinterface

// ===== src/jdtm_cfg_if.sv =====
// ----------------------------------------------------------------------------
// jdtm_cfg_if
// Configuration register write channel.
// ----------------------------------------------------------------------------
interface jdtm_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/jdtm_stage.sv =====
// ----------------------------------------------------------------------------
// jdtm_stage
// One register stage of the mixer pipeline; K selects the work it does.
// ----------------------------------------------------------------------------
module jdtm_stage #(
  parameter int K = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  jdtm_pkg::cfg_t  cfg,
  input  jdtm_pkg::item_t up_item,
  input  logic            up_valid,
  output logic            up_ready,
  output jdtm_pkg::item_t dn_item,
  output logic            dn_valid,
  input  logic            dn_ready
);

  localparam int CI = (K >= jdtm_pkg::CORDIC_FIRST && K < jdtm_pkg::ST_ANGLE) ?
                      K - jdtm_pkg::CORDIC_FIRST : 0;
  localparam int DB = (K >= jdtm_pkg::DIV_FIRST && K < jdtm_pkg::ST_FINAL) ?
                      jdtm_pkg::DIV_BITS - 1 - (K - jdtm_pkg::DIV_FIRST) : 0;

  function automatic logic [9:0] clamp_code(input logic [11:0] c);
    if (c < jdtm_pkg::CODE_LO) return 10'd0;
    else if (c > jdtm_pkg::CODE_HI) return jdtm_pkg::CODE_SPAN;
    else return 10'(c - jdtm_pkg::CODE_LO);
  endfunction

  function automatic logic [7:0] isqrt15(input logic [14:0] v);
    logic [15:0] rem;
    logic [15:0] res;
    logic [15:0] bt;
    rem = {1'b0, v};
    res = '0;
    bt  = 16'h4000;
    for (int i = 0; i < 8; i++) begin
      if (rem >= res + bt) begin
        rem = rem - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res[7:0];
  endfunction

  function automatic logic [9:0] sat_power(input logic signed [11:0] v);
    if (v < 0) return 10'd0;
    else if (v > $signed({2'b0, jdtm_pkg::POWER_MAX})) return jdtm_pkg::POWER_MAX;
    else return v[9:0];
  endfunction

  jdtm_pkg::item_t nx;

  always_comb begin
    logic [9:0]         dx;
    logic [9:0]         dy;
    logic [16:0]        mx;
    logic [16:0]        my;
    logic [40:0]        prx;
    logic [40:0]        pry;
    logic signed [16:0] sx;
    logic signed [16:0] sy;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] num;
    logic               fa_in;
    logic               side_in;
    logic signed [30:0] dabs;
    logic signed [26:0] shx;
    logic signed [26:0] shy;
    logic signed [15:0] zabs;
    logic [22:0]        nm;
    logic [40:0]        sub;
    logic [9:0]         qa;
    logic               rnz;
    logic signed [11:0] qe;
    logic signed [11:0] qp;
    logic signed [11:0] fpos;
    logic signed [11:0] fneg;
    logic signed [11:0] rr;
    logic signed [11:0] lv;
    logic signed [11:0] rv;

    nx = up_item;
    dx = '0; dy = '0; mx = '0; my = '0; prx = '0; pry = '0;
    sx = '0; sy = '0; vx = '0; vy = '0; num = '0; fa_in = 1'b0; side_in = 1'b0;
    dabs = '0; shx = '0; shy = '0; zabs = '0; nm = '0; sub = '0;
    qa = '0; rnz = 1'b0; qe = '0; qp = '0; fpos = '0; fneg = '0; rr = '0;
    lv = '0; rv = '0;

    if (K == jdtm_pkg::ST_SCALE) begin
      // (code - 32) * max_drive * 8, the 512/960 scale split as 8/15
      dx = clamp_code(up_item.xc);
      dy = clamp_code(up_item.yc);
      mx = {7'b0, dx} * {10'b0, cfg.max_drive};
      my = {7'b0, dy} * {10'b0, cfg.max_drive};
      nx.px = {mx, 3'b0};
      nx.py = {my, 3'b0};
    end

    if (K == jdtm_pkg::ST_RECIP) begin
      prx = {21'b0, up_item.px} * {20'b0, jdtm_pkg::RECIP15};
      pry = {21'b0, up_item.py} * {20'b0, jdtm_pkg::RECIP15};
      nx.qx = prx[39:24];
      nx.qy = pry[39:24];
    end

    if (K == jdtm_pkg::ST_DRIVE) begin
      sx = $signed({1'b0, up_item.qx}) - $signed({2'b0, cfg.max_drive, 8'b0});
      sy = $signed({1'b0, up_item.qy}) - $signed({2'b0, cfg.max_drive, 8'b0});
      nx.xd = sx[15:0];
      nx.yd = sy[15:0];
    end

    if (K == jdtm_pkg::ST_SQUARE) begin
      vx = up_item.xd[15] ? -up_item.xd : up_item.xd;
      vy = up_item.yd[15] ? -up_item.yd : up_item.yd;
      nx.ax  = vx[14:0];
      nx.ay  = vy[14:0];
      nx.xx  = 30'(vx[14:0]) * 30'(vx[14:0]);
      nx.yy  = 30'(vy[14:0]) * 30'(vy[14:0]);
      nx.tax = 31'(cfg.sector_tangent) * 31'(vx[14:0]);
      nx.tay = 31'(cfg.sector_tangent) * 31'(vy[14:0]);
      // cone angle operands, mirrored into the upper half plane
      num   = up_item.yd[15] ? -up_item.xd : up_item.xd;
      nx.cx = {4'b0, vy[14:0], 8'b0};
      nx.cy = {{3{num[15]}}, num, 8'b0};
      nx.cz = '0;
    end

    if (K == jdtm_pkg::ST_MODE) begin
      nx.s = 31'(up_item.xx) + 31'(up_item.yy);
      nx.d = $signed({1'b0, up_item.yy}) - $signed({1'b0, up_item.xx});
      fa_in   = ({up_item.ax, 16'b0} <= up_item.tay);
      side_in = ({up_item.ay, 16'b0} <= up_item.tax);
      if (up_item.ax < up_item.ay && fa_in) begin
        nx.mode = jdtm_pkg::MODE_CONE;
      end else if (up_item.ay < up_item.ax && side_in) begin
        nx.mode = up_item.xd[15] ? jdtm_pkg::MODE_PORT : jdtm_pkg::MODE_STBD;
      end else if (!up_item.xd[15]) begin
        nx.mode = up_item.yd[15] ? jdtm_pkg::MODE_Q2 : jdtm_pkg::MODE_Q1;
      end else if (up_item.yd[15] || up_item.yd == 16'sd0) begin
        nx.mode = jdtm_pkg::MODE_Q3;
      end else begin
        nx.mode = jdtm_pkg::MODE_Q4;
      end
    end

    if (K == jdtm_pkg::ST_ROOT) begin
      nx.r = isqrt15(up_item.s[30:16]);
    end

    if (K == jdtm_pkg::ST_PROD) begin
      dabs     = up_item.d[30] ? -up_item.d : up_item.d;
      nx.dprod = 38'(up_item.r) * 38'(dabs[29:0]);
      nx.dneg  = up_item.d[30];
    end

    if (K >= jdtm_pkg::CORDIC_FIRST && K < jdtm_pkg::ST_ANGLE) begin
      shx = up_item.cx >>> CI;
      shy = up_item.cy >>> CI;
      if (up_item.cy > 27'sd0) begin
        nx.cx = up_item.cx + shy;
        nx.cy = up_item.cy - shx;
        nx.cz = up_item.cz + jdtm_pkg::ATAN_TAB[CI];
      end else if (up_item.cy < 27'sd0) begin
        nx.cx = up_item.cx - shy;
        nx.cy = up_item.cy + shx;
        nx.cz = up_item.cz - jdtm_pkg::ATAN_TAB[CI];
      end
    end

    if (K == jdtm_pkg::ST_ANGLE) begin
      // shared divider operands: r times cone angle over tangent or r*D over S
      zabs = up_item.cz[15] ? -up_item.cz : up_item.cz;
      nm   = 23'(up_item.r) * 23'(zabs[14:0]);
      if (up_item.mode == jdtm_pkg::MODE_CONE) begin
        nx.a   = {14'b0, nm, 2'b0};
        nx.neg = up_item.cz[15];
        nx.dv  = {15'b0, cfg.sector_tangent};
      end else begin
        nx.a   = {1'b0, up_item.dprod};
        nx.neg = up_item.dneg;
        nx.dv  = up_item.s;
      end
    end

    if (K == jdtm_pkg::ST_DIVCHK) begin
      nx.dz  = (up_item.dv == '0);
      nx.ovf = (up_item.dv != '0) && ({2'b0, up_item.a} >= {up_item.dv, 10'b0});
      nx.q   = '0;
    end

    if (K >= jdtm_pkg::DIV_FIRST && K < jdtm_pkg::ST_FINAL) begin
      sub = {10'b0, up_item.dv} << DB;
      if (!up_item.dz && !up_item.ovf && {2'b0, up_item.a} >= sub) begin
        nx.a     = up_item.a - sub[38:0];
        nx.q[DB] = 1'b1;
      end
    end

    if (K == jdtm_pkg::ST_FINAL) begin
      qa   = up_item.ovf ? 10'h3FF : up_item.q;
      rnz  = up_item.ovf || (!up_item.dz && up_item.a != '0);
      qp   = $signed({2'b0, qa});
      qe   = qp + $signed({11'b0, rnz});
      fpos = up_item.neg ? -qe : qp;
      fneg = up_item.neg ? qp : -qe;
      rr   = $signed({4'b0, up_item.r});
      unique case (up_item.mode)
        jdtm_pkg::MODE_Q1: begin
          lv = jdtm_pkg::NEUTRAL + rr;   rv = jdtm_pkg::NEUTRAL + fneg;
        end
        jdtm_pkg::MODE_Q2: begin
          lv = jdtm_pkg::NEUTRAL + fneg; rv = jdtm_pkg::NEUTRAL + rr;
        end
        jdtm_pkg::MODE_Q3: begin
          lv = jdtm_pkg::NEUTRAL + fpos; rv = jdtm_pkg::NEUTRAL - rr;
        end
        jdtm_pkg::MODE_Q4: begin
          lv = jdtm_pkg::NEUTRAL - rr;   rv = jdtm_pkg::NEUTRAL + fneg;
        end
        jdtm_pkg::MODE_CONE: begin
          lv = jdtm_pkg::NEUTRAL + fpos; rv = jdtm_pkg::NEUTRAL + fneg;
        end
        jdtm_pkg::MODE_STBD: begin
          lv = jdtm_pkg::NEUTRAL + rr;   rv = jdtm_pkg::NEUTRAL + rr;
        end
        jdtm_pkg::MODE_PORT: begin
          lv = jdtm_pkg::NEUTRAL - rr;   rv = jdtm_pkg::NEUTRAL - rr;
        end
        default: begin
          lv = jdtm_pkg::NEUTRAL;        rv = jdtm_pkg::NEUTRAL;
        end
      endcase
      if (up_item.stop) begin
        lv = jdtm_pkg::NEUTRAL;
        rv = jdtm_pkg::NEUTRAL;
      end
      nx.left  = sat_power(lv);
      nx.right = sat_power(rv);
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_item <= nx;
    end
  end

endmodule

// ===== src/joystick_differential_thrust_mixer_top.sv =====
// ----------------------------------------------------------------------------
// joystick_differential_thrust_mixer_top
// Turns joystick samples into left/right thruster commands centred on 500.
// ----------------------------------------------------------------------------
//
//   channel  role    payload                              item
//   -------  ------  -----------------------------------  -----------------
//   joy      sink    x_code, y_code, stop_request         one stick sample
//   thrust   source  left_power, right_power              one command pair
//   cfg      sink    index, data (0 max_drive, 1 tangent) one register write
//
// one sample enters per cycle while the first stage can move; the stage chain
// is 32 registers deep (drive scaling in three, squares, 15 cordic steps that
// also carry mode, root and product, angle, divide check, 10 divide steps,
// final mix). the accepting edge loads the first register, and the sample
// passes through each register in order before it is offered on thrust.
// every stage has its own valid bit and moves when the stage after it is
// empty or moving, so a stalled output holds its item while earlier stages
// keep filling bubbles.
// synchronous reset clears the valid bits and loads the register defaults.
// cfg is always ready; the user must write registers only while no item is
// in flight, which the block itself does not enforce.
module joystick_differential_thrust_mixer_top (
  input logic           clk,
  input logic           rst,
  jdtm_joy_if.sink      joy,
  jdtm_thrust_if.source thrust,
  jdtm_cfg_if.sink      cfg
);

  // configuration registers
  logic [6:0]     max_drive;
  logic [15:0]    sector_tangent;
  jdtm_pkg::cfg_t cfg_word;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_drive      <= jdtm_pkg::MAX_DRIVE_RESET;
      sector_tangent <= jdtm_pkg::SECTOR_TANGENT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        jdtm_pkg::REG_MAX_DRIVE:      max_drive      <= cfg.data[6:0];
        jdtm_pkg::REG_SECTOR_TANGENT: sector_tangent <= cfg.data;
        default:                      max_drive      <= max_drive;
      endcase
    end
  end

  assign cfg_word.max_drive      = max_drive;
  assign cfg_word.sector_tangent = sector_tangent;

  // pipeline links: index k feeds stage k, stage k drives index k+1
  jdtm_pkg::item_t           stg_item  [jdtm_pkg::NSTG+1];
  logic [jdtm_pkg::NSTG:0]   stg_valid;
  logic [jdtm_pkg::NSTG:0]   stg_ready;
  jdtm_pkg::item_t           joy_item;

  // incoming sample into the item record
  always_comb begin
    joy_item      = '0;
    joy_item.xc   = joy.x_code;
    joy_item.yc   = joy.y_code;
    joy_item.stop = joy.stop_request;
  end

  assign stg_item[0]  = joy_item;
  assign stg_valid[0] = joy.valid;
  assign joy.ready    = stg_ready[0];

  for (genvar k = 0; k < jdtm_pkg::NSTG; k++) begin : g_stage
    jdtm_stage #(.K(k)) u_stage (
      .clk      (clk),
      .rst      (rst),
      .cfg      (cfg_word),
      .up_item  (stg_item[k]),
      .up_valid (stg_valid[k]),
      .up_ready (stg_ready[k]),
      .dn_item  (stg_item[k+1]),
      .dn_valid (stg_valid[k+1]),
      .dn_ready (stg_ready[k+1])
    );
  end

  // last stage register is the output register
  assign thrust.valid       = stg_valid[jdtm_pkg::NSTG];
  assign thrust.left_power  = stg_item[jdtm_pkg::NSTG].left;
  assign thrust.right_power = stg_item[jdtm_pkg::NSTG].right;
  assign stg_ready[jdtm_pkg::NSTG] = thrust.ready;

endmodule
